// ----- rtl/tst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tst_pkg;
  localparam int unsigned CmdW = 2;
  localparam int unsigned SlotFieldW = 4;
  localparam int unsigned TimeW = 32;
  localparam int unsigned TagW = 16;
  localparam int unsigned KindW = 3;
  localparam int unsigned SecW = 34;
  localparam int unsigned RateW = 16;

  localparam logic [CmdW-1:0] CmdTick   = 2'd0;
  localparam logic [CmdW-1:0] CmdCreate = 2'd1;
  localparam logic [CmdW-1:0] CmdRenew  = 2'd2;
  localparam logic [CmdW-1:0] CmdCancel = 2'd3;

  localparam logic [KindW-1:0] KindOk      = 3'd0;
  localparam logic [KindW-1:0] KindExpired = 3'd1;
  localparam logic [KindW-1:0] KindTick    = 3'd2;
  localparam logic [KindW-1:0] KindFull    = 3'd3;
  localparam logic [KindW-1:0] KindNotUsed = 3'd4;

  localparam logic CfgRate   = 1'b0;
  localparam logic CfgAdjust = 1'b1;

  typedef struct packed {
    logic [CmdW-1:0]       command;
    logic [SlotFieldW-1:0] slot;
    logic [TimeW-1:0]      timeout;
    logic [TagW-1:0]       tag;
  } req_t;

  typedef struct packed {
    logic [KindW-1:0]      kind;
    logic [SlotFieldW-1:0] slot_res;
    logic [TagW-1:0]       tag_res;
    logic [SecW-1:0]       seconds;
    logic                  last;
  } res_t;
endpackage
`default_nettype wire

// ----- rtl/tst_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface tst_req_if import tst_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tst_res_if import tst_pkg::*; ();
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/tst_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle
module tst_div import tst_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [TimeW-1:0] num_i,
  input  wire logic [RateW-1:0] den_i,
  output logic                  done_o,
  output logic [TimeW-1:0]      quo_o
);
  logic [TimeW-1:0] quo_q;
  logic [RateW:0]   rem_q;
  logic [RateW-1:0] den_q;
  logic [5:0]       cnt_q;
  logic             busy_q;
  logic [RateW:0]   trial;

  assign trial = {rem_q[RateW-1:0], quo_q[TimeW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(TimeW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= (den_i == '0) ? RateW'(1) : den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[TimeW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[TimeW-2:0], 1'b0};
      end
    end
  end

  assign quo_o = quo_q;
endmodule
`default_nettype wire

// ----- rtl/tst_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tst_datapath import tst_pkg::*; #(
  parameter int unsigned SLOTS = 16,
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire req_t             req_i,
  input  wire logic             tick_inc_i,
  input  wire logic             cnt_clr_i,
  input  wire logic             cnt_inc_i,
  input  wire logic             free_scan_i,
  input  wire logic             create_i,
  input  wire logic             renew_i,
  input  wire logic             cancel_i,
  input  wire logic             div_start_i,
  output logic                  scan_hit_o,
  output logic                  scan_end_o,
  output logic                  addr_live_o,
  output logic                  slot_live_o,
  output logic                  div_done_o,
  output logic [IdxW-1:0]       idx_o,
  output logic [TagW-1:0]       tag_o,
  output logic [TimeW-1:0]      quo_o,
  input  wire logic [RateW-1:0] rate_i
);
  logic [TimeW-1:0] expiry_mem [SLOTS];
  logic [TagW-1:0]  tag_mem [SLOTS];
  logic [SLOTS-1:0] live_q;
  logic [TimeW-1:0] tick_q;
  logic [IdxW:0]    cnt_q;
  logic [IdxW:0]    cnt_d;
  logic [TimeW-1:0] expiry_rd_q;
  logic [TagW-1:0]  tag_rd_q;
  req_t             req_q;
  logic [IdxW-1:0]  idx;
  logic [IdxW-1:0]  addr;
  logic             addr_ok;

  assign cnt_d = cnt_clr_i ? '0 : (cnt_inc_i ? cnt_q + (IdxW+1)'(1) : cnt_q);
  assign idx  = cnt_q[IdxW-1:0];
  assign idx_o = idx;
  assign addr = IdxW'(req_q.slot);
  assign addr_ok = (32'(req_q.slot) < SLOTS);
  assign addr_live_o = addr_ok && live_q[addr];
  assign scan_end_o = (cnt_q == (IdxW+1)'(SLOTS - 1));
  // read data registered from the next scan index, so it matches the current index
  assign scan_hit_o = live_q[idx] && (expiry_rd_q < tick_q);
  assign slot_live_o = live_q[idx];
  assign tag_o = tag_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      tick_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (tick_inc_i) tick_q <= tick_q + 32'd1;
      cnt_q <= cnt_d;
      if (free_scan_i) live_q[idx] <= 1'b0;
      if (create_i) live_q[idx] <= 1'b1;
      if (cancel_i) live_q[addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) req_q <= req_i;
    if (create_i) begin
      expiry_mem[idx] <= tick_q + req_q.timeout;
      tag_mem[idx]    <= req_q.tag;
    end
    if (renew_i) expiry_mem[addr] <= tick_q + req_q.timeout;
    expiry_rd_q <= expiry_mem[cnt_d[IdxW-1:0]];
    tag_rd_q    <= tag_mem[cnt_d[IdxW-1:0]];
  end

  tst_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_i),
    .num_i   (tick_q),
    .den_i   (rate_i),
    .done_o  (div_done_o),
    .quo_o   (quo_o)
  );
endmodule
`default_nettype wire

// ----- rtl/tst_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tst_ctrl import tst_pkg::*; #(
  parameter int unsigned SLOTS = 16,
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire req_t                   req_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output res_t                        res_o,
  output logic                        load_o,
  output logic                        tick_inc_o,
  output logic                        cnt_clr_o,
  output logic                        cnt_inc_o,
  output logic                        free_scan_o,
  output logic                        create_o,
  output logic                        renew_o,
  output logic                        cancel_o,
  output logic                        div_start_o,
  input  wire logic                   scan_hit_i,
  input  wire logic                   scan_end_i,
  input  wire logic                   addr_live_i,
  input  wire logic                   div_done_i,
  input  wire logic                   slot_live_i,
  input  wire logic [IdxW-1:0]        idx_i,
  input  wire logic [TagW-1:0]        tag_i,
  input  wire logic [TimeW-1:0]       quo_i,
  input  wire logic signed [TimeW-1:0] adjust_i
);
  typedef enum logic [2:0] {
    StIdle, StDecode, StScan, StDiv, StFind, StDone
  } state_e;

  state_e state_q;
  req_t   req_q;
  logic   scan_done_q;
  logic   out_free;
  logic   out_set;

  assign in_ready_o = (state_q == StIdle);
  assign load_o = in_valid_i && in_ready_o;
  assign out_free = !out_valid_o || out_ready_i;

  always_comb begin
    tick_inc_o = 1'b0; cnt_clr_o = 1'b0; cnt_inc_o = 1'b0; free_scan_o = 1'b0;
    create_o = 1'b0; renew_o = 1'b0; cancel_o = 1'b0; div_start_o = 1'b0;
    out_set = 1'b0;
    case (state_q)
      StIdle: begin
        if (load_o) begin
          cnt_clr_o = 1'b1;
          tick_inc_o = (req_i.command == CmdTick);
        end
      end
      StDecode: begin
        if (req_q.command == CmdTick) div_start_o = 1'b1;
        else if (req_q.command == CmdRenew) renew_o = addr_live_i;
        else if (req_q.command == CmdCancel) cancel_o = addr_live_i;
        out_set = (req_q.command != CmdTick);
      end
      StScan: begin
        if (out_free) begin
          free_scan_o = scan_hit_i;
          cnt_inc_o = !scan_end_i;
          out_set = scan_hit_i;
        end
      end
      StDiv: begin
        out_set = (div_done_i || scan_done_q) && out_free;
      end
      StFind: begin
        if (!slot_live_i) create_o = 1'b1;
        else cnt_inc_o = !scan_end_i;
        out_set = !slot_live_i || scan_end_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_o <= 1'b0;
      scan_done_q <= 1'b0;
    end else begin
      if (out_set) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      // the divider may finish while the scan is still held by the output
      if (state_q == StDecode) scan_done_q <= 1'b0;
      else if (div_done_i) scan_done_q <= 1'b1;
      case (state_q)
        StIdle: begin
          if (load_o) begin
            req_q <= req_i;
            state_q <= (req_i.command == CmdCreate) ? StFind : StDecode;
          end
        end
        StDecode: begin
          if (req_q.command == CmdTick) begin
            state_q <= StScan;
          end else begin
            res_o <= '{kind: addr_live_i ? KindOk : KindNotUsed,
                       slot_res: req_q.slot, tag_res: '0, seconds: '0, last: 1'b1};
            state_q <= StDone;
          end
        end
        StScan: begin
          if (out_free) begin
            if (scan_hit_i) begin
              res_o <= '{kind: KindExpired, slot_res: SlotFieldW'(idx_i),
                         tag_res: tag_i, seconds: '0, last: 1'b0};
            end
            if (scan_end_i) state_q <= StDiv;
          end
        end
        StDiv: begin
          if (out_set) begin
            res_o <= '{kind: KindTick, slot_res: '0, tag_res: '0,
                       seconds: SecW'({1'b0, quo_i}) + SecW'(adjust_i), last: 1'b1};
            state_q <= StDone;
          end
        end
        StFind: begin
          if (!slot_live_i) begin
            res_o <= '{kind: KindOk, slot_res: SlotFieldW'(idx_i), tag_res: req_q.tag,
                       seconds: '0, last: 1'b1};
            state_q <= StDone;
          end else if (scan_end_i) begin
            res_o <= '{kind: KindFull, slot_res: '0, tag_res: '0, seconds: '0, last: 1'b1};
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/timer_slot_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  payload                               transaction
// req       in   command, slot, timeout, tag           one command
// res       out  kind, slot_res, tag_res, seconds, last one result, last marks the end
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i       register write, no read-back
//
// create: the free-slot search walks one slot a cycle
// tick: a scan of all SLOTS slots, with the serial divider running alongside;
// a stalled result holds the scan and the end
// reset clears the counter, the live bits and the registers; no clearing pass
module timer_slot_table import tst_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tst_req_if.sink          req,
  tst_res_if.source        res,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [RateW-1:0]          rate_q;
  logic signed [TimeW-1:0]   adjust_q;
  logic load, tick_inc, cnt_clr, cnt_inc, free_scan, create, renew, cancel, div_start;
  logic scan_hit, scan_end, addr_live, div_done;
  logic [IdxW-1:0] idx;
  logic [TagW-1:0] tag;
  logic [TimeW-1:0] quo;
  logic live_at_idx;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= RateW'(100);
      adjust_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgRate) rate_q <= cfg_data_i[RateW-1:0];
      else adjust_q <= cfg_data_i;
    end
  end

  // during create, a slot is taken when its index is not live
  tst_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk_i, .rst_ni, .load_i(load), .req_i(req.payload),
    .tick_inc_i(tick_inc), .cnt_clr_i(cnt_clr), .cnt_inc_i(cnt_inc),
    .free_scan_i(free_scan), .create_i(create), .renew_i(renew), .cancel_i(cancel),
    .div_start_i(div_start), .scan_hit_o(scan_hit), .scan_end_o(scan_end),
    .addr_live_o(addr_live), .slot_live_o(live_at_idx), .div_done_o(div_done),
    .idx_o(idx), .tag_o(tag), .quo_o(quo), .rate_i(rate_q)
  );

  tst_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(req.valid), .req_i(req.payload),
    .in_ready_o(req.ready), .out_valid_o(res.valid), .out_ready_i(res.ready),
    .res_o(res.payload), .load_o(load), .tick_inc_o(tick_inc), .cnt_clr_o(cnt_clr),
    .cnt_inc_o(cnt_inc), .free_scan_o(free_scan), .create_o(create), .renew_o(renew),
    .cancel_o(cancel), .div_start_o(div_start), .scan_hit_i(scan_hit),
    .scan_end_i(scan_end), .addr_live_i(addr_live), .div_done_i(div_done),
    .slot_live_i(live_at_idx), .idx_i(idx), .tag_i(tag), .quo_i(quo),
    .adjust_i(adjust_q)
  );
endmodule
`default_nettype wire
